// ----- rtl/dcfl_pkg.sv -----
// ----------------------------------------------------------------------------
// dcfl_pkg
// Shared types and codes for the DER certificate field locator.
// ----------------------------------------------------------------------------
package dcfl_pkg;

    localparam logic [2:0] KIND_SERIAL  = 3'd0;
    localparam logic [2:0] KIND_ISSUER  = 3'd1;
    localparam logic [2:0] KIND_SUBJECT = 3'd2;
    localparam logic [2:0] KIND_KEY     = 3'd3;
    localparam logic [2:0] KIND_VERDICT = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TAG   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_EMPTY_BIT = 3'd4;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_VERSION  = 8'hA0;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] TAG_BITSTR   = 8'h03;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] offset;
        logic [16:0] length;
        logic [2:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- rtl/dcfl_parser.sv -----
// ----------------------------------------------------------------------------
// dcfl_parser
// TLV header decoder and X.509 layout checker; one byte per step.
// ----------------------------------------------------------------------------
module dcfl_parser #(
    parameter int MAX_CERT_BYTES    = 65536,
    parameter int MAX_LENGTH_OCTETS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_eod,
    output dcfl_pkg::t_push  o_push
);
    import dcfl_pkg::*;

    localparam int W  = $clog2(MAX_CERT_BYTES) + 2;
    localparam int XW = (W > 17) ? W : 17;
    localparam logic [W-1:0]   MAXP  = W'(MAX_CERT_BYTES);
    localparam logic [W-1:0]   SATV  = W'(MAX_CERT_BYTES + 1);
    localparam logic [W+7:0]   MAXPW = (W+8)'(MAX_CERT_BYTES);
    localparam logic [6:0]     MAXLO = 7'(MAX_LENGTH_OCTETS);

    localparam logic [3:0] STEP_CERT     = 4'd0;
    localparam logic [3:0] STEP_TBS      = 4'd1;
    localparam logic [3:0] STEP_FIRST    = 4'd2;
    localparam logic [3:0] STEP_SERIAL   = 4'd3;
    localparam logic [3:0] STEP_SIGALG   = 4'd4;
    localparam logic [3:0] STEP_ISSUER   = 4'd5;
    localparam logic [3:0] STEP_VALIDITY = 4'd6;
    localparam logic [3:0] STEP_SUBJECT  = 4'd7;
    localparam logic [3:0] STEP_SPKI     = 4'd8;
    localparam logic [3:0] STEP_ALG      = 4'd9;
    localparam logic [3:0] STEP_BITS     = 4'd10;
    localparam logic [3:0] STEP_DONE     = 4'd11;
    localparam logic [3:0] STEP_FAILED   = 4'd12;

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN1 = 2'd1;
    localparam logic [1:0] PH_LENN = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [W-1:0] r_pos,   n_pos;
    logic [3:0]   r_step,  n_step;
    logic [1:0]   r_phase, n_phase;
    logic [7:0]   r_tag,   n_tag;
    logic [W-1:0] r_len,   n_len;
    logic [2:0]   r_left,  n_left;
    logic [W-1:0] r_start, n_start;
    logic [W-1:0] r_skip,  n_skip;
    logic [W-1:0] r_req,   n_req;
    logic [2:0]   r_err,   n_err;

    logic [W+7:0] acc_wide;
    logic [W-1:0] acc_sat;
    logic [W-1:0] len_now;
    logic [W-1:0] content;
    logic [W-1:0] end_pos;
    logic [W-1:0] total;
    logic [XW-1:0] x_start, x_total, x_key_off, x_key_len;
    logic         hdr_done;
    logic         tag_ok;
    logic         has_field;
    logic         has_verdict;
    t_result      field_res;
    t_result      verdict_res;

    assign acc_wide = {r_len, i_byte};
    assign acc_sat  = (acc_wide > MAXPW) ? SATV : acc_wide[W-1:0];
    assign len_now  = (r_phase == PH_LEN1) ? W'(i_byte) : acc_sat;
    assign content  = r_pos + W'(1);
    assign end_pos  = content + len_now;
    assign total    = content - r_start + len_now;
    assign x_start   = XW'(r_start);
    assign x_total   = XW'(total);
    assign x_key_off = XW'(content) + XW'(1);
    assign x_key_len = XW'(len_now) - XW'(1);

    always_comb begin
        case (r_step)
            STEP_FIRST:  tag_ok = (r_tag == TAG_VERSION) || (r_tag == TAG_INTEGER);
            STEP_SERIAL: tag_ok = (r_tag == TAG_INTEGER);
            STEP_BITS:   tag_ok = (r_tag == TAG_BITSTR);
            default:     tag_ok = (r_tag == TAG_SEQUENCE);
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_step  = r_step;
        n_phase = r_phase;
        n_tag   = r_tag;
        n_len   = r_len;
        n_left  = r_left;
        n_start = r_start;
        n_skip  = r_skip;
        n_req   = r_req;
        n_err   = r_err;
        hdr_done    = 1'b0;
        has_field   = 1'b0;
        has_verdict = 1'b0;
        field_res   = '0;
        verdict_res = '0;

        if (i_step && (r_pos < MAXP)) begin
            n_pos = r_pos + W'(1);
            if (r_step < STEP_DONE) begin
                case (r_phase)
                    PH_TAG: begin
                        n_start = r_pos;
                        n_tag   = i_byte;
                        n_phase = PH_LEN1;
                    end
                    PH_LEN1: begin
                        if (!i_byte[7]) begin
                            n_len    = len_now;
                            hdr_done = 1'b1;
                        end else if ((i_byte[6:0] == 7'd0) || (i_byte[6:0] > MAXLO)) begin
                            n_err   = ST_BAD_LEN;
                            n_step  = STEP_FAILED;
                            n_phase = PH_TAG;
                        end else begin
                            n_left  = i_byte[2:0];
                            n_len   = '0;
                            n_phase = PH_LENN;
                        end
                    end
                    PH_LENN: begin
                        n_len    = len_now;
                        n_left   = r_left - 3'd1;
                        hdr_done = (r_left == 3'd1);
                    end
                    default: begin
                        if (content >= r_skip) n_phase = PH_TAG;
                    end
                endcase
            end
        end

        if (hdr_done) begin
            if (end_pos > MAXP) begin
                n_err   = ST_TRUNC;
                n_step  = STEP_FAILED;
                n_phase = PH_TAG;
            end else if (!tag_ok) begin
                n_err   = ST_BAD_TAG;
                n_step  = STEP_FAILED;
                n_phase = PH_TAG;
            end else if ((r_step == STEP_BITS) && (len_now == '0)) begin
                n_err   = ST_EMPTY_BIT;
                n_step  = STEP_FAILED;
                n_phase = PH_TAG;
            end else begin
                if (end_pos > r_req) n_req = end_pos;
                n_phase = (len_now == '0) ? PH_TAG : PH_SKIP;
                n_skip  = (len_now == '0) ? r_skip : end_pos;
                field_res.offset = x_start[15:0];
                field_res.length = x_total[16:0];
                field_res.status = ST_OK;
                case (r_step)
                    STEP_CERT: begin
                        n_step  = STEP_TBS;
                        n_phase = PH_TAG;
                        n_skip  = r_skip;
                    end
                    STEP_TBS: begin
                        n_step  = STEP_FIRST;
                        n_phase = PH_TAG;
                        n_skip  = r_skip;
                    end
                    STEP_FIRST: begin
                        if (r_tag == TAG_VERSION) begin
                            n_step = STEP_SERIAL;
                        end else begin
                            n_step          = STEP_SIGALG;
                            has_field       = 1'b1;
                            field_res.kind  = KIND_SERIAL;
                        end
                    end
                    STEP_SERIAL: begin
                        n_step         = STEP_SIGALG;
                        has_field      = 1'b1;
                        field_res.kind = KIND_SERIAL;
                    end
                    STEP_SIGALG:   n_step = STEP_ISSUER;
                    STEP_ISSUER: begin
                        n_step         = STEP_VALIDITY;
                        has_field      = 1'b1;
                        field_res.kind = KIND_ISSUER;
                    end
                    STEP_VALIDITY: n_step = STEP_SUBJECT;
                    STEP_SUBJECT: begin
                        n_step         = STEP_SPKI;
                        has_field      = 1'b1;
                        field_res.kind = KIND_SUBJECT;
                    end
                    STEP_SPKI: begin
                        n_step  = STEP_ALG;
                        n_phase = PH_TAG;
                        n_skip  = r_skip;
                    end
                    STEP_ALG:      n_step = STEP_BITS;
                    default: begin
                        n_step           = STEP_DONE;
                        n_phase          = PH_TAG;
                        n_skip           = r_skip;
                        has_field        = 1'b1;
                        field_res.kind   = KIND_KEY;
                        field_res.offset = x_key_off[15:0];
                        field_res.length = x_key_len[16:0];
                    end
                endcase
            end
        end

        if (i_step && i_eod) begin
            has_verdict      = 1'b1;
            verdict_res.kind = KIND_VERDICT;
            verdict_res.last = 1'b1;
            if (n_err != ST_OK)          verdict_res.status = n_err;
            else if (n_step != STEP_DONE) verdict_res.status = ST_TRUNC;
            else if (n_req > n_pos)       verdict_res.status = ST_TRUNC;
            else                          verdict_res.status = ST_OK;
            n_pos   = '0;
            n_step  = STEP_CERT;
            n_phase = PH_TAG;
            n_tag   = '0;
            n_len   = '0;
            n_left  = '0;
            n_start = '0;
            n_skip  = '0;
            n_req   = '0;
            n_err   = ST_OK;
        end
        field_res.last = !has_verdict;
    end

    always_comb begin
        o_push.num  = {1'b0, has_field} + {1'b0, has_verdict};
        o_push.res0 = has_field ? field_res : verdict_res;
        o_push.res1 = verdict_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_step  <= STEP_CERT;
            r_phase <= PH_TAG;
            r_tag   <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_start <= '0;
            r_skip  <= '0;
            r_req   <= '0;
            r_err   <= ST_OK;
        end else begin
            r_pos   <= n_pos;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_left  <= n_left;
            r_start <= n_start;
            r_skip  <= n_skip;
            r_req   <= n_req;
            r_err   <= n_err;
        end
    end

endmodule

// ----- rtl/dcfl_result_fifo.sv -----
// ----------------------------------------------------------------------------
// dcfl_result_fifo
// Small result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module dcfl_result_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dcfl_pkg::t_push             i_push,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dcfl_pkg::t_result           o_res,
    output logic [dcfl_pkg::FIFO_CW-1:0] o_count
);
    import dcfl_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp,    n_wp;
    logic [FIFO_AW-1:0]   r_rp,    n_rp;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp    = r_wp + FIFO_AW'(i_push.num);
        n_rp    = r_rp + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_push.num) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_mem[r_wp] <= i_push.res0;
        if (i_push.num == 2'd2) r_mem[r_wp + FIFO_AW'(1)] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/der_certificate_field_locator_unit.sv -----
// ----------------------------------------------------------------------------
// der_certificate_field_locator_unit
// Locates serial, issuer, subject and public key in a DER certificate stream
// and gives a verdict on the last byte.
//
//   Channel  Dir  tdata                           tuser        tlast
//   s        in   [7:0] data_byte                 -            end_of_data
//   m        out  [15:0] field_offset,            result_kind  last_of_run
//                 [32:16] field_length,
//                 [35:33] status, [39:36] zero
//
// One byte a cycle: input register, one pass of header decode, then a
// four-entry result queue. Results are pushed as a byte leaves the input register.
// A byte with a field and a verdict pushes both together; they leave one at a time.
// Input stalls while the queue holds more than two results.
// Synchronous active-low reset; parser state also clears after every verdict.
// ----------------------------------------------------------------------------
module der_certificate_field_locator_unit #(
    parameter int MAX_CERT_BYTES    = 65536,
    parameter int MAX_LENGTH_OCTETS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_data
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] offset, [32:16] length, [35:33] status
    output logic [2:0]  o_m_tuser,   // [2:0] result_kind
    output logic        o_m_tlast    // last_of_run
);
    import dcfl_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eod;
    logic                 adv;
    logic                 in_acc;
    t_push                w_push;
    t_result              w_res;
    logic [FIFO_CW-1:0]   w_count;

    assign adv        = r_in_valid && (w_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_s_tready = !r_in_valid || adv;
    assign in_acc     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_s_tdata;
            r_in_eod  <= i_s_tlast;
        end
    end

    dcfl_parser #(
        .MAX_CERT_BYTES    (MAX_CERT_BYTES),
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_byte  (r_in_byte),
        .i_eod   (r_in_eod),
        .o_push  (w_push)
    );

    dcfl_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_res),
        .o_count (w_count)
    );

    assign o_m_tdata = {4'b0000, w_res.status, w_res.length, w_res.offset};
    assign o_m_tuser = w_res.kind;
    assign o_m_tlast = w_res.last;

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_VERDICT) |-> o_m_tlast)
        else $error("verdict not marked last");

    a_field_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != KIND_VERDICT) |-> (o_m_tdata[35:33] == ST_OK))
        else $error("field result with non-ok status");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= KIND_VERDICT))
        else $error("result kind out of range");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the DER certificate field locator. Byte buffers are
// fed through the input stream: small well-formed certificates with random
// content and length forms, damaged ones (bad bytes, cut short, empty key,
// huge lengths) and plain noise.
// A local parser works out the located fields and verdicts for every accepted
// request; the output stream is compared against them in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dcfl_pkg::*;

    localparam int CERT_LIMIT = 65536;
    localparam int LEN_OCTETS = 4;

    typedef enum logic [3:0] {
        L_CERT, L_TBS, L_FIRST, L_SERIAL, L_SIGALG, L_ISSUER, L_VALIDITY,
        L_SUBJECT, L_SPKI, L_ALG, L_BITS, L_DONE, L_FAILED
    } layout_e;

    typedef enum logic [1:0] {H_TAG, H_LEN1, H_LENN, H_SKIP} hdr_e;

    typedef logic [7:0] octets_t[$];

    typedef struct {
        logic [7:0] octet;
        logic       eod;
        int         gap;
    } feed_item_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = '0;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    der_certificate_field_locator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // local parser state
    logic [16:0] at_pos;
    layout_e     step;
    hdr_e        phase;
    logic [7:0]  el_tag;
    logic [16:0] len_acc;
    logic [2:0]  len_left;
    logic [16:0] el_start;
    logic [16:0] skip_end;
    logic [16:0] need_end;
    logic [2:0]  err_code;

    t_result     expected_fields[$];
    feed_item_t  byte_feed[$];
    feed_item_t  feed_now;
    logic        feed_armed = 1'b0;
    t_result     seen;
    t_result     want;

    int fails        = 0;
    int bytes_taken  = 0;
    int total_bytes  = 0;
    int results_seen = 0;
    int hold_left    = 0;
    int rx_wait      = 0;
    bit rx_calm      = 1'b0;
    int cycles       = 0;
    int cycle_limit  = 32'h7fff_ffff;

    logic [7:0] tiny_cert [21] = '{
        TAG_SEQUENCE, 8'h00, TAG_SEQUENCE, 8'h00, TAG_INTEGER, 8'h00,
        TAG_SEQUENCE, 8'h00, TAG_SEQUENCE, 8'h00, TAG_SEQUENCE, 8'h00,
        TAG_SEQUENCE, 8'h00, TAG_SEQUENCE, 8'h00, TAG_SEQUENCE, 8'h00,
        TAG_BITSTR, 8'h01, 8'h00
    };

    function automatic void clear_parser();
        at_pos   = '0;
        step     = L_CERT;
        phase    = H_TAG;
        el_tag   = '0;
        len_acc  = '0;
        len_left = '0;
        el_start = '0;
        skip_end = '0;
        need_end = '0;
        err_code = ST_OK;
    endfunction

    function automatic void report_field(logic [2:0] kind, int off, int len, logic [2:0] st);
        t_result r;
        r.kind   = kind;
        r.offset = off[15:0];
        r.length = len[16:0];
        r.status = st;
        r.last   = 1'b0;
        expected_fields.push_back(r);
    endfunction

    function automatic void fail_with(logic [2:0] code);
        err_code = code;
        step     = L_FAILED;
        phase    = H_TAG;
    endfunction

    function automatic void skip_past(int el_end, layout_e nxt);
        step = nxt;
        if (len_acc == 0) begin
            phase = H_TAG;
        end else begin
            skip_end = el_end[16:0];
            phase    = H_SKIP;
        end
    endfunction

    function automatic void header_complete(int p);
        int   body;
        int   el_end;
        int   total;
        logic tag_ok;
        body   = p + 1;
        el_end = body + int'(len_acc);
        total  = body - int'(el_start) + int'(len_acc);
        if (el_end > CERT_LIMIT) begin
            fail_with(ST_TRUNC);
            return;
        end
        case (step)
            L_FIRST:  tag_ok = (el_tag == TAG_VERSION || el_tag == TAG_INTEGER);
            L_SERIAL: tag_ok = (el_tag == TAG_INTEGER);
            L_BITS:   tag_ok = (el_tag == TAG_BITSTR);
            default:  tag_ok = (el_tag == TAG_SEQUENCE);
        endcase
        if (!tag_ok) begin
            fail_with(ST_BAD_TAG);
            return;
        end
        if (step == L_BITS && len_acc == 0) begin
            fail_with(ST_EMPTY_BIT);
            return;
        end
        if (el_end > int'(need_end)) need_end = el_end[16:0];
        case (step)
            L_CERT: begin
                step  = L_TBS;
                phase = H_TAG;
            end
            L_TBS: begin
                step  = L_FIRST;
                phase = H_TAG;
            end
            L_FIRST: begin
                if (el_tag == TAG_VERSION) begin
                    skip_past(el_end, L_SERIAL);
                end else begin
                    report_field(KIND_SERIAL, el_start, total, ST_OK);
                    skip_past(el_end, L_SIGALG);
                end
            end
            L_SERIAL: begin
                report_field(KIND_SERIAL, el_start, total, ST_OK);
                skip_past(el_end, L_SIGALG);
            end
            L_SIGALG:   skip_past(el_end, L_ISSUER);
            L_ISSUER: begin
                report_field(KIND_ISSUER, el_start, total, ST_OK);
                skip_past(el_end, L_VALIDITY);
            end
            L_VALIDITY: skip_past(el_end, L_SUBJECT);
            L_SUBJECT: begin
                report_field(KIND_SUBJECT, el_start, total, ST_OK);
                skip_past(el_end, L_SPKI);
            end
            L_SPKI: begin
                step  = L_ALG;
                phase = H_TAG;
            end
            L_ALG:      skip_past(el_end, L_BITS);
            default: begin
                report_field(KIND_KEY, body + 1, int'(len_acc) - 1, ST_OK);
                step  = L_DONE;
                phase = H_TAG;
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eod);
        int         p;
        int         acc;
        int         prior_count;
        logic [2:0] verdict;
        t_result    r;
        prior_count = expected_fields.size();
        if (at_pos < CERT_LIMIT) begin
            p      = at_pos;
            at_pos = at_pos + 1'b1;
            if (step < L_DONE) begin
                case (phase)
                    H_TAG: begin
                        el_start = p[16:0];
                        el_tag   = b;
                        phase    = H_LEN1;
                    end
                    H_LEN1: begin
                        if (b < 8'h80) begin
                            len_acc = {9'd0, b};
                            header_complete(p);
                        end else if (b[6:0] == 0 || b[6:0] > LEN_OCTETS) begin
                            fail_with(ST_BAD_LEN);
                        end else begin
                            len_left = b[2:0];
                            len_acc  = '0;
                            phase    = H_LENN;
                        end
                    end
                    H_LENN: begin
                        acc = (int'(len_acc) << 8) | int'(b);
                        if (acc > CERT_LIMIT) acc = CERT_LIMIT + 1;
                        len_acc  = acc[16:0];
                        len_left = len_left - 1'b1;
                        if (len_left == 0) header_complete(p);
                    end
                    default: begin
                        if (p + 1 >= int'(skip_end)) phase = H_TAG;
                    end
                endcase
            end
        end
        if (eod) begin
            if (err_code != ST_OK) verdict = err_code;
            else if (step != L_DONE || need_end > at_pos) verdict = ST_TRUNC;
            else verdict = ST_OK;
            report_field(KIND_VERDICT, 0, 0, verdict);
            clear_parser();
        end
        if (expected_fields.size() > prior_count) begin
            r      = expected_fields.pop_back();
            r.last = 1'b1;
            expected_fields.push_back(r);
        end
    endfunction

    function automatic octets_t random_octets(int n);
        octets_t q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 24) == 0) return $urandom_range(120, 160);
        return $urandom_range(0, 6);
    endfunction

    // tag, length in a random short or long form, then the content
    function automatic octets_t tlv(logic [7:0] tag, octets_t body);
        octets_t q;
        int      n;
        int      k;
        int      i;
        n = body.size();
        q.push_back(tag);
        if (n < 128 && $urandom_range(0, 3) != 0) begin
            q.push_back(8'(n));
        end else begin
            k = (n < 256) ? 1 : (n < 65536) ? 2 : 3;
            k = $urandom_range(k, LEN_OCTETS);
            q.push_back(8'h80 | 8'(k));
            for (i = k - 1; i >= 0; i--) q.push_back(8'(n >> (8 * i)));
        end
        foreach (body[j]) q.push_back(body[j]);
        return q;
    endfunction

    function automatic octets_t build_tbs(bit empty_key);
        octets_t ver;
        octets_t key;
        if ($urandom_range(0, 1) == 1) ver = tlv(TAG_VERSION, tlv(TAG_INTEGER, random_octets(1)));
        if (empty_key) begin
            key.push_back(TAG_BITSTR);
            key.push_back(8'h00);
        end else begin
            key = tlv(TAG_BITSTR, random_octets(1 + pick_size()));
        end
        return tlv(TAG_SEQUENCE, {ver,
                                  tlv(TAG_INTEGER, random_octets(pick_size())),
                                  tlv(TAG_SEQUENCE, random_octets(pick_size())),
                                  tlv(TAG_SEQUENCE, random_octets(pick_size())),
                                  tlv(TAG_SEQUENCE, random_octets(pick_size())),
                                  tlv(TAG_SEQUENCE, random_octets(pick_size())),
                                  tlv(TAG_SEQUENCE,
                                      {tlv(TAG_SEQUENCE, random_octets(pick_size())), key})});
    endfunction

    function automatic octets_t build_cert(bit empty_key);
        return tlv(TAG_SEQUENCE, {build_tbs(empty_key),
                                  tlv(TAG_SEQUENCE, random_octets($urandom_range(0, 6))),
                                  tlv(TAG_BITSTR, random_octets($urandom_range(1, 12)))});
    endfunction

    function automatic void queue_buffer(octets_t q, bit calm);
        feed_item_t it;
        foreach (q[i]) begin
            it.octet = q[i];
            it.eod   = (i == q.size() - 1);
            it.gap   = calm ? 0 : $urandom_range(0, 10);
            byte_feed.push_back(it);
        end
    endfunction

    initial begin
        octets_t     cert;
        octets_t     scratch;
        int          random_bytes;
        int          pick;
        int          flaw;
        int          i;
        bit          calm;
        logic [31:0] lenword;

        clear_parser();
        random_bytes = 0;

        // directed: smallest complete layout, bad length form, lone final byte
        foreach (tiny_cert[j]) scratch.push_back(tiny_cert[j]);
        queue_buffer(scratch, 1'b0);
        scratch.delete();
        scratch.push_back(TAG_SEQUENCE);
        scratch.push_back(8'h85);
        queue_buffer(scratch, 1'b0);
        scratch.delete();
        scratch.push_back(8'($urandom));
        queue_buffer(scratch, 1'b0);

        while (random_bytes < 1800) begin
            pick = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            if (pick < 55) begin
                cert = build_cert(1'b0);
                if ($urandom_range(0, 3) == 0) cert = {cert, random_octets($urandom_range(1, 8))};
            end else if (pick < 85) begin
                flaw = $urandom_range(0, 3);
                cert = build_cert(flaw == 2);
                case (flaw)
                    0: cert[$urandom_range(0, cert.size() - 1)] = 8'($urandom);
                    1: begin
                        i = $urandom_range(1, cert.size() - 1);
                        while (cert.size() > i) void'(cert.pop_back());
                    end
                    3: begin
                        case ($urandom_range(0, 2))
                            0:       lenword = 32'hFFFF_FFFF;
                            1:       lenword = $urandom;
                            default: lenword = 32'h0000_FFF0 + $urandom_range(0, 15);
                        endcase
                        scratch.delete();
                        scratch.push_back(TAG_SEQUENCE);
                        scratch.push_back(8'h84);
                        for (i = 3; i >= 0; i--) scratch.push_back(8'(lenword >> (8 * i)));
                        cert = {scratch, build_tbs(1'b0)};
                    end
                    default: ;
                endcase
            end else begin
                cert = random_octets($urandom_range(1, 16));
                if ($urandom_range(0, 1) == 1) cert[0] = TAG_SEQUENCE;
            end
            queue_buffer(cert, calm);
            random_bytes += cert.size();
        end

        total_bytes = byte_feed.size();
        cycle_limit = 4 * 34 * total_bytes + 20000;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total_bytes) @(posedge i_clk);
        while (expected_fields.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fails == 0 && expected_fields.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tlast  <= 1'b0;
            feed_armed = 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_byte(i_s_tdata, i_s_tlast);
                bytes_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (!feed_armed && byte_feed.size() > 0) begin
                    feed_now   = byte_feed.pop_front();
                    feed_armed = 1'b1;
                end
                if (feed_armed && feed_now.gap == 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= feed_now.octet;
                    i_s_tlast  <= feed_now.eod;
                    feed_armed = 1'b0;
                end else begin
                    i_s_tvalid <= 1'b0;
                    if (feed_armed) feed_now.gap = feed_now.gap - 1;
                end
            end
        end
    end

    // result monitor; two long hold-offs let the result queue fill and stall input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                seen = {o_m_tuser, o_m_tdata[15:0], o_m_tdata[32:16], o_m_tdata[35:33],
                        o_m_tlast};
                if (expected_fields.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result kind %0d offset %0d length %0d status %0d",
                             $time, seen.kind, seen.offset, seen.length, seen.status);
                end else begin
                    want = expected_fields.pop_front();
                    if (seen !== want) begin
                        fails++;
                        $display({"%0t: mismatch: expected kind %0d offset %0d length %0d ",
                                  "status %0d last %0d, got kind %0d offset %0d length %0d ",
                                  "status %0d last %0d"},
                                 $time, want.kind, want.offset, want.length, want.status,
                                 want.last, seen.kind, seen.offset, seen.length, seen.status,
                                 seen.last);
                    end
                end
                results_seen++;
                if (results_seen == 20 || results_seen == 60) hold_left = 400;
                if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > cycle_limit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
